[rtl/core/bayes_question_selector_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the question selector
// Implication checks on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef BAYES_QUESTION_SELECTOR_ASSERT_SVH
`define BAYES_QUESTION_SELECTOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[rtl/core/bqs_pkg.sv]
// ----------------------------------------------------------------------------
// Question selector package
// Widths, codes and shared constants of the question selector.
// ----------------------------------------------------------------------------
`default_nettype none
package bqs_pkg;
    localparam int PROB_W    = 16;
    localparam int HYP_N     = 16;
    localparam int Q_N       = 32;
    localparam int HYP_IW    = 4;
    localparam int Q_IW      = 5;
    localparam int SCORE_W   = 21;
    localparam int DIV_W     = 34;
    localparam int QUO_W     = PROB_W + 1;
    localparam int EV_W      = 2 * PROB_W + 1;
    localparam int EV_DEPTH  = HYP_N * Q_N;
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [QUO_W-1:0] PROB_ONE = {1'b1, {PROB_W{1'b0}}};

    typedef enum logic [2:0] {
        OP_LOAD_PRIOR = 3'd0,
        OP_LOAD_EVID  = 3'd1,
        OP_START      = 3'd2,
        OP_ANSWER     = 3'd3,
        OP_STOP       = 3'd4,
        OP_READ_PRIOR = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;
endpackage
`default_nettype wire

[rtl/core/bqs_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/core/bqs_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// Computes dividend * 2^16 / divisor, one quotient bit per cycle; the
// dividend must not exceed the divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module bqs_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bqs_pkg::DIV_W-1:0] dividend,
    input  wire logic [bqs_pkg::DIV_W-1:0] divisor,
    output logic                           done,
    output logic      [bqs_pkg::QUO_W-1:0] quotient
);
    import bqs_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic [DIV_W:0]   rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;
    logic [DIV_W:0]   diff;

    assign ge       = rem_reg >= {1'b0, den_reg};
    assign diff     = ge ? rem_reg - {1'b0, den_reg} : rem_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= {1'b0, dividend};
                den_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= {diff[DIV_W-1:0], 1'b0};
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/bayes_question_selector.sv]
// ----------------------------------------------------------------------------
// Bayesian question selector
// Knowledge base of priors and evidence with a sequenced posterior engine.
// ----------------------------------------------------------------------------
// Items enter on the s_ group: the opcode in s_tuser, the operands in s_tdata.
// Every item gives exactly one result item on the m_ group: next question,
// running flag and prior in m_tdata, status in m_tuser.
// Loads, reads and stop give their result in the cycle after they are taken.
// Start and answer rescore every hypothesis and question pair in use, apart
// from questions already asked. Each pair with evidence takes two posteriors,
// each of two multiplies and a division on the one shared divider; a pair
// without evidence is read and skipped. An answer first takes up to one level
// division and up to 16 updates.
// s_tready is high only while the sequencer is idle and no result waits.
// A result stays in m_tdata until m_tready takes it; no new item is taken
// before that.
// After reset all 512 evidence entries are cleared, one entry per cycle, and
// no item is accepted meanwhile; configuration writes are taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bayes_question_selector_assert.svh"
module bayes_question_selector (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // hyp_index, question_index, prior_in, prob_yes, prob_no,
    // evidence_present, level
    input  wire logic [79:0] s_tdata,
    // opcode
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // next_question, running, prior_out
    output logic      [23:0] m_tdata,
    // status
    output logic      [1:0]  m_tuser,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [15:0] wr_data
);
    import bqs_pkg::*;

    localparam logic [1:0] CFG_YES = 2'd0;
    localparam logic [1:0] CFG_NO  = 2'd1;
    localparam logic [1:0] CFG_HYP = 2'd2;
    localparam logic [1:0] CFG_Q   = 2'd3;
    localparam int EV_AW = $clog2(EV_DEPTH);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_N_CALC, S_N_WAIT,
        S_A_RD, S_A_CHK, S_A_MUL, S_A_WR, S_A_NEXT,
        S_R_QSTART, S_R_RD, S_R_CHK, S_R_B, S_R_ACC, S_R_HNEXT, S_R_QEND,
        S_SELECT, S_P_MX, S_P_MY, S_P_ADD, S_P_WAIT
    } state_t;

    typedef enum logic [1:0] {
        SEL_A, SEL_B, SEL_NO
    } sel_t;

    state_t state_reg, ret_reg;
    sel_t   sel_reg;

    logic signed [15:0] yes_reg, no_reg, level_reg;
    logic [4:0]  hyp_use_reg;
    logic [5:0]  q_use_reg;
    logic [PROB_W-1:0] orig_reg [HYP_N];
    logic [PROB_W-1:0] cur_reg  [HYP_N];
    logic [Q_N-1:0]    used_reg;
    logic [Q_IW-1:0]   cq_reg, bq_reg;
    logic              running_reg, ov_reg, neg_reg;
    logic [PROB_W-1:0] prior_out_reg;
    status_t           status_reg;
    logic [HYP_IW:0]   h_reg;
    logic [Q_IW:0]     q_reg;
    logic [EV_AW-1:0]  clr_reg;
    logic [SCORE_W-1:0] acc_reg, best_reg;
    logic [QUO_W-1:0]  a_reg, post_reg, w_reg;
    logic [31:0]       x_reg;
    logic [33:0]       prod_reg;
    logic [PROB_W-1:0] py_reg, pn_reg;

    logic [HYP_IW:0] hcnt;
    logic [Q_IW:0]   qcnt;
    op_t             op_in;
    logic [HYP_IW-1:0] h_in;
    logic [Q_IW-1:0]   q_in;
    logic [PROB_W-1:0] prior_in, py_in, pn_in;
    logic              present_in;
    logic signed [15:0] level_in;
    logic              accept, h_ok, q_ok;

    logic [PROB_W-1:0] p_cur;
    logic [QUO_W-1:0]  mul_a, mul_b;
    logic [QUO_W-1:0]  post_diff;
    logic signed [17:0] n_num, n_den;
    logic [17:0]       n_anum, n_aden;
    logic [QUO_W-1:0]  ab_diff;
    logic [SCORE_W:0]  acc_sum;
    logic [33:0]       p_den;
    logic [17:0]       upd_mag;
    logic [PROB_W+2:0] upd_up;

    logic              ram_we;
    logic [EV_AW-1:0]  ram_waddr, ram_raddr;
    logic [EV_W-1:0]   ram_wdata, ram_rdata;

    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_dividend, div_divisor;
    logic [QUO_W-1:0]  div_quo;

    assign hcnt = (hyp_use_reg > (HYP_IW+1)'(HYP_N)) ? (HYP_IW+1)'(HYP_N) : hyp_use_reg;
    assign qcnt = (q_use_reg > (Q_IW+1)'(Q_N)) ? (Q_IW+1)'(Q_N) : q_use_reg;

    assign op_in      = op_t'(s_tuser);
    assign h_in       = s_tdata[3:0];
    assign q_in       = s_tdata[8:4];
    assign prior_in   = s_tdata[24:9];
    assign py_in      = s_tdata[40:25];
    assign pn_in      = s_tdata[56:41];
    assign present_in = s_tdata[57];
    assign level_in   = s_tdata[73:58];

    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign accept   = s_tvalid && s_tready;
    assign h_ok     = {1'b0, h_in} < hcnt;
    assign q_ok     = {1'b0, q_in} < qcnt;

    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, prior_out_reg, running_reg,
                       running_reg ? cq_reg : {Q_IW{1'b0}}};
    assign m_tuser  = status_reg;

    assign p_cur = cur_reg[h_reg[HYP_IW-1:0]];

    assign n_den  = 18'(yes_reg) - 18'(no_reg);
    assign n_num  = 18'(level_reg) + 18'(level_reg) - 18'(yes_reg) - 18'(no_reg);
    assign n_anum = n_num[17] ? 18'(-n_num) : 18'(n_num);
    assign n_aden = n_den[17] ? 18'(-n_den) : 18'(n_den);

    assign post_diff = (post_reg >= {1'b0, p_cur}) ? post_reg - {1'b0, p_cur}
                                                   : {1'b0, p_cur} - post_reg;
    assign ab_diff   = (a_reg >= post_reg) ? a_reg - post_reg : post_reg - a_reg;
    assign acc_sum   = {1'b0, acc_reg} + (SCORE_W+1)'(ab_diff);
    assign p_den     = {2'b00, x_reg} + prod_reg;
    assign upd_mag   = prod_reg[33:16];
    assign upd_up    = (PROB_W+3)'(p_cur) + (PROB_W+3)'(upd_mag);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_P_MX:
            begin
                mul_b = {1'b0, p_cur};
                case (sel_reg)
                    SEL_A:   mul_a = {1'b0, py_reg};
                    SEL_B:   mul_a = {1'b0, pn_reg};
                    default: mul_a = PROB_ONE - {1'b0, py_reg};
                endcase
            end
            S_P_MY:
            begin
                mul_b = PROB_ONE - {1'b0, p_cur};
                if (sel_reg == SEL_A)
                    mul_a = {1'b0, pn_reg};
                else
                    mul_a = PROB_ONE - {1'b0, pn_reg};
            end
            S_A_MUL:
            begin
                mul_a = post_diff;
                mul_b = w_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {2'b00, x_reg};
        div_divisor  = p_den;
        if (state_reg == S_N_CALC)
        begin
            div_dividend = DIV_W'(n_anum);
            div_divisor  = DIV_W'(n_aden);
            div_start    = (n_den != 18'sd0) && (n_num != 18'sd0) && (n_anum < n_aden);
        end
        else if (state_reg == S_P_ADD)
        begin
            div_start = p_den != 34'd0;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {h_in, q_in};
        ram_wdata = {present_in, py_in, pn_in};
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (accept && op_in == OP_LOAD_EVID && h_ok && q_ok)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        if (state_reg == S_A_RD)
            ram_raddr = {h_reg[HYP_IW-1:0], cq_reg};
        else
            ram_raddr = {h_reg[HYP_IW-1:0], q_reg[Q_IW-1:0]};
    end

    bqs_ram #(
        .WIDTH(EV_W),
        .DEPTH(EV_DEPTH)
    ) u_ev_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    bqs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .done    (div_done),
        .quotient(div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            ret_reg     <= S_IDLE;
            sel_reg     <= SEL_A;
            yes_reg     <= 16'sd1;
            no_reg      <= -16'sd1;
            hyp_use_reg <= '0;
            q_use_reg   <= '0;
            used_reg    <= '0;
            cq_reg      <= '0;
            running_reg <= 1'b0;
            ov_reg      <= 1'b0;
            status_reg  <= STAT_OK;
            clr_reg     <= '0;
            h_reg       <= '0;
            q_reg       <= '0;
        end
        else
        begin
            prod_reg <= 34'(mul_a * mul_b);
            if (wr_en)
            begin
                case (wr_index)
                    CFG_YES: yes_reg     <= wr_data;
                    CFG_NO:  no_reg      <= wr_data;
                    CFG_HYP: hyp_use_reg <= wr_data[4:0];
                    CFG_Q:   q_use_reg   <= wr_data[5:0];
                    default: ;
                endcase
            end
            if (ov_reg && m_tready)
                ov_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == EV_AW'(EV_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        level_reg     <= level_in;
                        prior_out_reg <= '0;
                        status_reg    <= STAT_OK;
                        ov_reg        <= 1'b1;
                        case (op_in)
                            OP_LOAD_PRIOR:
                            begin
                                if (h_ok)
                                begin
                                    orig_reg[h_in] <= prior_in;
                                    cur_reg[h_in]  <= prior_in;
                                end
                                else
                                    status_reg <= STAT_RANGE;
                            end
                            OP_LOAD_EVID:
                            begin
                                if (!(h_ok && q_ok))
                                    status_reg <= STAT_RANGE;
                            end
                            OP_START:
                            begin
                                ov_reg   <= 1'b0;
                                used_reg <= '0;
                                cur_reg  <= orig_reg;
                                q_reg    <= '0;
                                best_reg <= '0;
                                bq_reg   <= '0;
                                state_reg <= S_R_QSTART;
                            end
                            OP_ANSWER:
                            begin
                                if (running_reg)
                                begin
                                    ov_reg    <= 1'b0;
                                    state_reg <= S_N_CALC;
                                end
                                else
                                    status_reg <= STAT_IGNORED;
                            end
                            OP_STOP:
                                running_reg <= 1'b0;
                            OP_READ_PRIOR:
                            begin
                                if (h_ok)
                                    prior_out_reg <= cur_reg[h_in];
                                else
                                    status_reg <= STAT_RANGE;
                            end
                            default: ;
                        endcase
                    end
                end
                S_N_CALC:
                begin
                    neg_reg  <= n_num[17] ^ n_den[17];
                    h_reg    <= '0;
                    q_reg    <= '0;
                    best_reg <= '0;
                    bq_reg   <= '0;
                    if (n_den == 18'sd0 || n_num == 18'sd0)
                        state_reg <= S_R_QSTART;
                    else if (n_anum >= n_aden)
                    begin
                        w_reg     <= PROB_ONE;
                        state_reg <= (hcnt == '0) ? S_R_QSTART : S_A_RD;
                    end
                    else
                        state_reg <= S_N_WAIT;
                end
                S_N_WAIT:
                begin
                    if (div_done)
                    begin
                        w_reg <= div_quo;
                        if (div_quo == '0 || hcnt == '0)
                            state_reg <= S_R_QSTART;
                        else
                            state_reg <= S_A_RD;
                    end
                end
                S_A_RD:
                    state_reg <= S_A_CHK;
                S_A_CHK:
                begin
                    py_reg <= ram_rdata[EV_W-2:PROB_W];
                    pn_reg <= ram_rdata[PROB_W-1:0];
                    if (ram_rdata[EV_W-1])
                    begin
                        sel_reg   <= neg_reg ? SEL_NO : SEL_A;
                        ret_reg   <= S_A_MUL;
                        state_reg <= S_P_MX;
                    end
                    else
                        state_reg <= S_A_NEXT;
                end
                S_A_MUL:
                    state_reg <= S_A_WR;
                S_A_WR:
                begin
                    if (post_reg >= {1'b0, p_cur})
                        cur_reg[h_reg[HYP_IW-1:0]] <=
                            (upd_up > (PROB_W+3)'({PROB_W{1'b1}})) ? {PROB_W{1'b1}}
                                                                   : upd_up[PROB_W-1:0];
                    else
                        cur_reg[h_reg[HYP_IW-1:0]] <=
                            (upd_mag > 18'(p_cur)) ? '0 : PROB_W'(18'(p_cur) - upd_mag);
                    state_reg <= S_A_NEXT;
                end
                S_A_NEXT:
                begin
                    h_reg <= h_reg + 1'b1;
                    if (h_reg + 1'b1 == hcnt)
                        state_reg <= S_R_QSTART;
                    else
                        state_reg <= S_A_RD;
                end
                S_R_QSTART:
                begin
                    acc_reg <= '0;
                    h_reg   <= '0;
                    if (q_reg >= qcnt)
                        state_reg <= S_SELECT;
                    else if (used_reg[q_reg[Q_IW-1:0]] || hcnt == '0)
                        state_reg <= S_R_QEND;
                    else
                        state_reg <= S_R_RD;
                end
                S_R_RD:
                    state_reg <= S_R_CHK;
                S_R_CHK:
                begin
                    py_reg <= ram_rdata[EV_W-2:PROB_W];
                    pn_reg <= ram_rdata[PROB_W-1:0];
                    if (ram_rdata[EV_W-1])
                    begin
                        sel_reg   <= SEL_A;
                        ret_reg   <= S_R_B;
                        state_reg <= S_P_MX;
                    end
                    else
                        state_reg <= S_R_HNEXT;
                end
                S_R_B:
                begin
                    a_reg     <= post_reg;
                    sel_reg   <= SEL_B;
                    ret_reg   <= S_R_ACC;
                    state_reg <= S_P_MX;
                end
                S_R_ACC:
                begin
                    acc_reg   <= acc_sum[SCORE_W] ? SCORE_MAX : acc_sum[SCORE_W-1:0];
                    state_reg <= S_R_HNEXT;
                end
                S_R_HNEXT:
                begin
                    h_reg <= h_reg + 1'b1;
                    if (h_reg + 1'b1 == hcnt)
                        state_reg <= S_R_QEND;
                    else
                        state_reg <= S_R_RD;
                end
                S_R_QEND:
                begin
                    if (acc_reg > best_reg)
                    begin
                        best_reg <= acc_reg;
                        bq_reg   <= q_reg[Q_IW-1:0];
                    end
                    q_reg     <= q_reg + 1'b1;
                    state_reg <= S_R_QSTART;
                end
                S_SELECT:
                begin
                    if (best_reg == '0)
                        running_reg <= 1'b0;
                    else
                    begin
                        used_reg[bq_reg] <= 1'b1;
                        cq_reg           <= bq_reg;
                        running_reg      <= 1'b1;
                    end
                    ov_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_P_MX:
                    state_reg <= S_P_MY;
                S_P_MY:
                begin
                    x_reg     <= prod_reg[31:0];
                    state_reg <= S_P_ADD;
                end
                S_P_ADD:
                begin
                    if (p_den == 34'd0)
                    begin
                        post_reg  <= {1'b0, p_cur};
                        state_reg <= ret_reg;
                    end
                    else
                        state_reg <= S_P_WAIT;
                end
                S_P_WAIT:
                begin
                    if (div_done)
                    begin
                        post_reg  <= div_quo;
                        state_reg <= ret_reg;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_SAME(a_run_q, clk, rst_n, running_reg && state_reg == S_IDLE, {1'b0, cq_reg} < 6'(Q_N))
    `ASSERT_SAME(a_div_wait, clk, rst_n, div_done, state_reg == S_P_WAIT || state_reg == S_N_WAIT)
    `ASSERT_SAME(a_clear_quiet, clk, rst_n, state_reg == S_CLEAR, !s_tready && !m_tvalid)
    `ASSERT_NEXT(a_sel_used, clk, rst_n, state_reg == S_SELECT && best_reg != '0, used_reg[cq_reg])
endmodule
`default_nettype wire

[bench/bayes_question_selector_test.sv]
// ----------------------------------------------------------------------------
// Question selector testbench
// Drives load, start, answer, stop and read items on the input stream,
// predicts every result from its own copy of the knowledge base and compares
// each result item field by field, under several idling and register settings.
// ----------------------------------------------------------------------------
`default_nettype none
module bayes_question_selector_test;
    import bqs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_YES_LEVEL = 2'd0;
    localparam logic [1:0] REG_NO_LEVEL  = 2'd1;
    localparam logic [1:0] REG_HYP_COUNT = 2'd2;
    localparam logic [1:0] REG_Q_COUNT   = 2'd3;
    localparam logic [2:0] OP_SPARE_A    = 3'd6;
    localparam logic [2:0] OP_SPARE_B    = 3'd7;
    localparam longint ONE = 65536;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [4:0]  next_q;
        logic        running;
        logic [15:0] prior;
        logic [1:0]  status;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [79:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0] m_tuser;
    logic wr_en = 1'b0;
    logic [1:0] wr_index = '0;
    logic [15:0] wr_data = '0;

    bayes_question_selector uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always #2 clk = ~clk;

    // Predictor state.
    longint yes_lv, no_lv;
    int unsigned hyp_cnt, q_cnt;
    longint unsigned kb_orig [16];
    longint unsigned kb_cur [16];
    longint unsigned ev_yes [512];
    longint unsigned ev_no [512];
    bit ev_valid [512];
    bit q_used [32];
    longint unsigned q_score [32];
    int unsigned pending_q;
    bit session_on;

    answer_t pending_answers [$];
    int errors = 0;
    int items_sent = 0;
    int idle_mode = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    function automatic int unsigned hyp_cap();
        return hyp_cnt > 16 ? 16 : hyp_cnt;
    endfunction

    function automatic int unsigned q_cap();
        return q_cnt > 32 ? 32 : q_cnt;
    endfunction

    function automatic longint unsigned bayes_div(longint unsigned num, longint unsigned den,
                                                  longint unsigned fb);
        if (den == 0)
            return fb;
        return (num << 16) / den;
    endfunction

    function automatic void rescore_questions();
        longint unsigned p, py, pn, a, b, diff, s;
        int idx;
        for (int q = 0; q < 32; q++)
            q_score[q] = 0;
        for (int h = 0; h < hyp_cap(); h++)
        begin
            p = kb_cur[h];
            for (int q = 0; q < q_cap(); q++)
            begin
                idx = h * 32 + q;
                if (!ev_valid[idx] || q_used[q])
                    continue;
                py = ev_yes[idx];
                pn = ev_no[idx];
                a = bayes_div(py * p, py * p + pn * (ONE - p), p);
                b = bayes_div(pn * p, pn * p + (ONE - pn) * (ONE - p), p);
                diff = a > b ? a - b : b - a;
                s = q_score[q] + diff;
                q_score[q] = s > 64'h1FFFFF ? 64'h1FFFFF : s;
            end
        end
    endfunction

    function automatic void pick_question();
        longint unsigned best;
        int unsigned bq;
        best = 0;
        bq = 0;
        for (int q = 0; q < q_cap(); q++)
            if (q_score[q] > best)
            begin
                best = q_score[q];
                bq = q;
            end
        if (best == 0)
        begin
            session_on = 0;
            return;
        end
        q_used[bq] = 1;
        pending_q = bq;
        session_on = 1;
    endfunction

    function automatic longint answer_weight(longint lv);
        longint den, num, n;
        den = yes_lv - no_lv;
        num = 2 * lv - yes_lv - no_lv;
        if (den == 0)
            return 0;
        n = (num * ONE) / den;
        if (n > ONE)
            n = ONE;
        if (n < -ONE)
            n = -ONE;
        return n;
    endfunction

    function automatic void update_priors(longint n);
        longint unsigned p, py, pn, target;
        longint w, d, np;
        int idx;
        if (n == 0)
            return;
        for (int h = 0; h < hyp_cap(); h++)
        begin
            idx = h * 32 + pending_q;
            if (!ev_valid[idx])
                continue;
            p = kb_cur[h];
            py = ev_yes[idx];
            pn = ev_no[idx];
            if (n > 0)
            begin
                target = bayes_div(py * p, py * p + pn * (ONE - p), p);
                w = n;
            end
            else
            begin
                target = bayes_div((ONE - py) * p,
                                   (ONE - py) * p + (ONE - pn) * (ONE - p), p);
                w = -n;
            end
            d = (longint'(target) - longint'(p)) * w;
            np = longint'(p) + d / ONE;
            if (np < 0)
                np = 0;
            if (np > ONE - 1)
                np = ONE - 1;
            kb_cur[h] = np;
        end
    endfunction

    function automatic answer_t predict_answer(logic [2:0] op, logic [3:0] h, logic [4:0] q,
                                               logic [15:0] prior, logic [15:0] py,
                                               logic [15:0] pn, logic ev,
                                               logic signed [15:0] lv);
        answer_t r;
        r = '0;
        r.status = STAT_OK;
        case (op)
            OP_LOAD_PRIOR:
                if (h < hyp_cap())
                begin
                    kb_orig[h] = prior;
                    kb_cur[h] = prior;
                end
                else
                    r.status = STAT_RANGE;
            OP_LOAD_EVID:
                if (h < hyp_cap() && q < q_cap())
                begin
                    ev_valid[h * 32 + q] = ev;
                    if (ev)
                    begin
                        ev_yes[h * 32 + q] = py;
                        ev_no[h * 32 + q] = pn;
                    end
                end
                else
                    r.status = STAT_RANGE;
            OP_START:
            begin
                for (int i = 0; i < 32; i++)
                    q_used[i] = 0;
                for (int i = 0; i < 16; i++)
                    kb_cur[i] = kb_orig[i];
                rescore_questions();
                pick_question();
            end
            OP_ANSWER:
                if (!session_on)
                    r.status = STAT_IGNORED;
                else
                begin
                    update_priors(answer_weight(longint'(lv)));
                    rescore_questions();
                    pick_question();
                end
            OP_STOP:
                session_on = 0;
            OP_READ_PRIOR:
                if (h < hyp_cap())
                    r.prior = 16'(kb_cur[h]);
                else
                    r.status = STAT_RANGE;
            default: ;
        endcase
        r.next_q = session_on ? pending_q[4:0] : 5'd0;
        r.running = session_on;
        return r;
    endfunction

    function automatic bit sender_idles();
        return (idle_mode == 1 && $urandom_range(99) < 47) ||
               (idle_mode == 3 && $urandom_range(99) < 37);
    endfunction

    function automatic bit receiver_stalls();
        return (idle_mode == 2 && $urandom_range(99) < 47) ||
               (idle_mode == 3 && $urandom_range(99) < 37);
    endfunction

    task automatic send_item(logic [2:0] op, logic [3:0] h, logic [4:0] q, logic [15:0] prior,
                             logic [15:0] py, logic [15:0] pn, logic ev,
                             logic signed [15:0] lv);
        while (sender_idles())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'b0, lv, ev, pn, py, prior, q, h};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_answers.push_back(predict_answer(op, h, q, prior, py, pn, ev, lv));
        items_sent++;
    endtask

    task automatic send_simple(logic [2:0] op, logic [3:0] h, logic signed [15:0] lv);
        send_item(op, h, 5'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom), lv);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_YES_LEVEL: yes_lv = longint'($signed(value));
            REG_NO_LEVEL:  no_lv = longint'($signed(value));
            REG_HYP_COUNT: hyp_cnt = value[4:0];
            default:       q_cnt = value[5:0];
        endcase
        @(posedge clk);
    endtask

    task automatic set_registers(int yes_v, int no_v, int hc, int qc);
        write_reg(REG_YES_LEVEL, 16'(yes_v));
        write_reg(REG_NO_LEVEL, 16'(no_v));
        write_reg(REG_HYP_COUNT, 16'(hc));
        write_reg(REG_Q_COUNT, 16'(qc));
    endtask

    always @(posedge clk)
    begin
        answer_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tdata[4:0], m_tdata[5], m_tdata[21:6], m_tuser};
            if (pending_answers.size() == 0)
            begin
                $display("%0t unexpected result item %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got.next_q !== want.next_q)
                begin
                    $display("%0t next_question expected %0d actual %0d",
                             $time, want.next_q, got.next_q);
                    errors++;
                end
                if (got.running !== want.running)
                begin
                    $display("%0t running expected %0d actual %0d",
                             $time, want.running, got.running);
                    errors++;
                end
                if (got.prior !== want.prior)
                begin
                    $display("%0t prior_out expected %0d actual %0d",
                             $time, want.prior, got.prior);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t status expected %0d actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !receiver_stalls();
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_empty_base();
        send_simple(OP_LOAD_PRIOR, 4'd0, 16'sd0);
        send_simple(OP_READ_PRIOR, 4'd15, 16'sd0);
        send_simple(OP_ANSWER, 4'd0, 16'sd1);
        send_simple(OP_STOP, 4'd0, 16'sd0);
        send_simple(OP_SPARE_A, 4'd0, 16'sd0);
        send_simple(OP_SPARE_B, 4'd0, 16'sd0);
        send_simple(OP_START, 4'd0, 16'sd0);
        drain_results();
    endtask

    task automatic test_load_priors();
        set_registers(1, -1, 16, 32);
        for (int h = 0; h < 16; h++)
            send_item(OP_LOAD_PRIOR, h[3:0], 5'($urandom),
                      h == 0 ? 16'd0 : h == 1 ? 16'hFFFF : 16'($urandom),
                      16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
        drain_results();
    endtask

    task automatic test_session_directed();
        send_item(OP_LOAD_EVID, 4'd1, 5'd0, 16'($urandom), 16'hFFFF, 16'h0000, 1'b1, 16'sd0);
        send_item(OP_LOAD_EVID, 4'd2, 5'd31, 16'($urandom), 16'h0000, 16'hFFFF, 1'b1, 16'sd0);
        send_item(OP_LOAD_EVID, 4'd3, 5'd5, 16'($urandom), 16'hC000, 16'h2000, 1'b1, 16'sd0);
        send_item(OP_LOAD_EVID, 4'd15, 5'd5, 16'($urandom), 16'h9000, 16'h4000, 1'b1, 16'sd0);
        send_item(OP_LOAD_EVID, 4'd3, 5'd5, 16'($urandom), 16'($urandom), 16'($urandom),
                  1'b0, 16'sd0);
        send_item(OP_LOAD_EVID, 4'd15, 5'd31, 16'($urandom), 16'h8000, 16'h7000, 1'b1,
                  16'sd0);
        send_simple(OP_START, 4'd0, 16'sd0);
        send_simple(OP_ANSWER, 4'd0, 16'sh7FFF);
        send_simple(OP_READ_PRIOR, 4'd1, 16'sd0);
        send_simple(OP_ANSWER, 4'd0, 16'sd0);
        send_simple(OP_ANSWER, 4'd0, -16'sh8000);
        send_simple(OP_READ_PRIOR, 4'd15, 16'sd0);
        send_simple(OP_STOP, 4'd0, 16'sd0);
        send_simple(OP_ANSWER, 4'd0, 16'sd1);
        drain_results();
    endtask

    task automatic test_level_settings();
        set_registers(32767, -32768, 31, 63);
        send_simple(OP_START, 4'd0, 16'sd0);
        send_simple(OP_ANSWER, 4'd0, 16'sd100);
        send_simple(OP_READ_PRIOR, 4'd15, 16'sd0);
        drain_results();
        set_registers(7, 7, 16, 32);
        send_simple(OP_START, 4'd0, 16'sd0);
        send_simple(OP_ANSWER, 4'd0, 16'sh7FFF);
        drain_results();
        set_registers(-50, 50, 16, 8);
        send_item(OP_LOAD_EVID, 4'd0, 5'd20, 16'($urandom), 16'($urandom), 16'($urandom),
                  1'b1, 16'sd0);
        send_simple(OP_START, 4'd0, 16'sd0);
        send_simple(OP_ANSWER, 4'd0, -16'sd50);
        drain_results();
    endtask

    task automatic test_backpressure();
        idle_mode = 0;
        hold_left = 400;
        for (int i = 0; i < 6; i++)
            send_simple(OP_READ_PRIOR, 4'($urandom_range(3)), 16'sd0);
        drain_results();
    endtask

    task automatic test_random(int mode, int count, int yes_v, int no_v, int hc, int qc);
        int first;
        int span;
        logic signed [15:0] lv;
        set_registers(yes_v, no_v, hc, qc);
        idle_mode = mode;
        first = items_sent;
        span = yes_v > no_v ? yes_v - no_v : no_v - yes_v;
        while (items_sent - first < count)
        begin
            if ($urandom_range(99) < 70)
            begin
                repeat ($urandom_range(3, 1))
                    send_item(OP_LOAD_EVID, 4'($urandom_range(hc - 1)),
                              5'($urandom_range(qc - 1)), 16'($urandom), 16'($urandom),
                              16'($urandom), $urandom_range(9) != 0, 16'($urandom));
                if ($urandom_range(3) == 0)
                    send_item(OP_LOAD_PRIOR, 4'($urandom_range(hc - 1)), 5'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                              16'($urandom));
                send_simple(OP_START, 4'($urandom), 16'($urandom));
                repeat ($urandom_range(3, 1))
                begin
                    case ($urandom_range(3))
                        0: lv = 16'(yes_v);
                        1: lv = 16'(no_v);
                        2: lv = 16'($urandom);
                        default: lv = 16'((yes_v < no_v ? yes_v : no_v) +
                                          $urandom_range(span));
                    endcase
                    send_simple(OP_ANSWER, 4'($urandom), lv);
                end
                send_simple(OP_READ_PRIOR, 4'($urandom_range(hc - 1)), 16'($urandom));
            end
            else
                send_item(3'($urandom_range(7)), 4'($urandom), 5'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
        end
        drain_results();
    endtask

    initial
    begin
        yes_lv = 1;
        no_lv = -1;
        hyp_cnt = 0;
        q_cnt = 0;
        pending_q = 0;
        session_on = 0;
        for (int i = 0; i < 16; i++)
        begin
            kb_orig[i] = 0;
            kb_cur[i] = 0;
        end
        for (int i = 0; i < 512; i++)
        begin
            ev_valid[i] = 0;
            ev_yes[i] = 0;
            ev_no[i] = 0;
        end
        for (int i = 0; i < 32; i++)
        begin
            q_used[i] = 0;
            q_score[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_base();
        test_load_priors();
        test_session_directed();
        test_level_settings();
        test_backpressure();
        test_random(0, 12, 100, -100, 3, 6);
        test_random(1, 12, 32767, -32768, 1, 1);
        test_random(2, 12, 0, 0, 4, 8);
        test_random(3, 12, -1000, 2000, 2, 4);
        idle_mode = 0;
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
